// ===== rtl/sgcq_pkg.sv =====
// shared types and constants for the spatial grid collision query block
package sgcq_pkg;

  localparam int ID_W       = 16;
  localparam int POS_W      = 24;
  localparam int RAD_W      = 16;
  localparam int LAY_W      = 8;
  localparam int CFG_W      = 20;
  localparam int CFG_ADDR_W = 2;
  localparam int OP_W       = 3;
  localparam int STS_W      = 3;
  localparam int SEP_W      = 25;
  localparam int DIFF_W     = POS_W + 1;
  localparam int D2_W       = 50;
  localparam int RQ_W       = 2 * (RAD_W + 1);
  localparam int BND_W      = 48;
  localparam int DQ_W       = 26;
  localparam int DIV_STEPS  = POS_W;
  localparam int DIV_CNT_W  = 5;
  localparam int SQ_STEPS   = SEP_W;
  localparam int SQ_CNT_W   = 5;
  localparam int SQ_REM_W   = SEP_W + 1;
  localparam int PIPE_D     = 4;
  localparam int DR_W       = 2;
  localparam int IN_DATA_W  = 112;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_CELL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TOL  = 2'd1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam logic [CFG_W-1:0] CELL_RST = 20'd800;
  localparam logic [CFG_W-1:0] TOL_RST  = 20'd400;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 3'd0,
    OP_ADD       = 3'd1,
    OP_MOVE_KEEP = 3'd2,
    OP_MOVE_SET  = 3'd3,
    OP_QUERY     = 3'd4,
    OP_MINSEP    = 3'd5
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 3'd0,
    STS_UNSAFE  = 3'd1,
    STS_UNKNOWN = 3'd2,
    STS_BADID   = 3'd3,
    STS_FULL    = 3'd4
  } sts_t;

  typedef enum logic [1:0] {
    SM_FIND  = 2'd0,
    SM_QUERY = 2'd1,
    SM_PAIR  = 2'd2
  } scan_mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_DRAIN,
    S_POST,
    S_DIV_GO,
    S_DIV_WAIT,
    S_SQ_GO,
    S_SQ_WAIT,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic [LAY_W-1:0]        layer;
    logic [RAD_W-1:0]        radius;
    logic signed [POS_W-1:0] z;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] x;
    logic [ID_W-1:0]         id;
  } slot_t;

  typedef struct packed {
    logic       latch;
    logic       clr_all;
    logic       rd_en;
    scan_mode_t mode;
    logic       div_start;
    logic [1:0] axis;
    logic       sq_start;
    logic       wr_add;
    logic       wr_move;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_zero;
    logic            found;
    logic            free_found;
    logic            pair_found;
    logic            cfg_zero;
    logic            div_busy;
    logic            sq_busy;
    logic            out_busy;
  } dp_stat_t;

endpackage

// ===== rtl/sgcq_ctrl.sv =====
// controller state machine: sequences scans, divisions, root and result
module sgcq_ctrl #(
  parameter int MAX_AGENTS = 64,
  localparam int AW = $clog2(MAX_AGENTS)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  sgcq_pkg::dp_stat_t stat,
  output sgcq_pkg::cmd_t     cmd,
  output logic [AW-1:0]      rd_a,
  output logic [AW-1:0]      rd_b
);

  sgcq_pkg::ctrl_state_t state_r, state_nxt;
  sgcq_pkg::scan_mode_t  kind_r, kind_nxt;
  logic [AW-1:0]               ca_r, ca_nxt, cb_r, cb_nxt;
  logic [sgcq_pkg::DR_W-1:0]   dr_r, dr_nxt;
  logic [1:0]                  ax_r, ax_nxt;

  // state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sgcq_pkg::S_IDLE;
      kind_r  <= sgcq_pkg::SM_FIND;
      ca_r    <= '0;
      cb_r    <= '0;
      dr_r    <= '0;
      ax_r    <= sgcq_pkg::AX_X;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      ca_r    <= ca_nxt;
      cb_r    <= cb_nxt;
      dr_r    <= dr_nxt;
      ax_r    <= ax_nxt;
    end
  end

  assign rd_a = ca_r;
  assign rd_b = cb_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    dr_nxt    = dr_r;
    ax_nxt    = ax_r;
    in_tready = 1'b0;
    cmd       = '0;
    cmd.mode  = kind_r;
    cmd.axis  = ax_r;
    case (state_r)
      sgcq_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = sgcq_pkg::S_DECODE;
        end
      end
      sgcq_pkg::S_DECODE: begin
        state_nxt = sgcq_pkg::S_DONE;
        case (sgcq_pkg::op_t'(stat.op))
          sgcq_pkg::OP_CLEAR: begin
            cmd.clr_all = 1'b1;
          end
          sgcq_pkg::OP_ADD, sgcq_pkg::OP_MOVE_KEEP, sgcq_pkg::OP_MOVE_SET,
          sgcq_pkg::OP_QUERY: begin
            if (stat.id_zero) begin
              cmd.clr_all = (sgcq_pkg::op_t'(stat.op) == sgcq_pkg::OP_ADD);
            end else begin
              kind_nxt  = sgcq_pkg::SM_FIND;
              ca_nxt    = '0;
              cb_nxt    = '0;
              state_nxt = sgcq_pkg::S_SCAN;
            end
          end
          sgcq_pkg::OP_MINSEP: begin
            if (!stat.cfg_zero) begin
              kind_nxt  = sgcq_pkg::SM_PAIR;
              ca_nxt    = '0;
              cb_nxt    = AW'(1);
              state_nxt = sgcq_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end
      sgcq_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (cb_r == AW'(MAX_AGENTS - 1)) begin
          if (kind_r != sgcq_pkg::SM_PAIR || ca_r == AW'(MAX_AGENTS - 2)) begin
            dr_nxt    = '0;
            state_nxt = sgcq_pkg::S_DRAIN;
          end else begin
            ca_nxt = ca_r + AW'(1);
            cb_nxt = ca_r + AW'(1) + AW'(1);
          end
        end else begin
          cb_nxt = cb_r + AW'(1);
        end
      end
      sgcq_pkg::S_DRAIN: begin
        dr_nxt = dr_r + sgcq_pkg::DR_W'(1);
        if (dr_r == sgcq_pkg::DR_W'(sgcq_pkg::PIPE_D - 1)) begin
          case (kind_r)
            sgcq_pkg::SM_FIND:  state_nxt = sgcq_pkg::S_POST;
            sgcq_pkg::SM_PAIR:  state_nxt = stat.pair_found ? sgcq_pkg::S_SQ_GO
                                                             : sgcq_pkg::S_DONE;
            default:            state_nxt = sgcq_pkg::S_DONE;
          endcase
        end
      end
      sgcq_pkg::S_POST: begin
        state_nxt = sgcq_pkg::S_DONE;
        case (sgcq_pkg::op_t'(stat.op))
          sgcq_pkg::OP_ADD: begin
            if (stat.found || !stat.free_found) begin
              cmd.clr_all = 1'b1;
            end else begin
              cmd.wr_add = 1'b1;
            end
          end
          sgcq_pkg::OP_MOVE_KEEP, sgcq_pkg::OP_MOVE_SET: begin
            cmd.wr_move = stat.found;
          end
          sgcq_pkg::OP_QUERY: begin
            if (stat.found && !stat.cfg_zero) begin
              ax_nxt    = sgcq_pkg::AX_X;
              state_nxt = sgcq_pkg::S_DIV_GO;
            end
          end
          default: begin
          end
        endcase
      end
      sgcq_pkg::S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = sgcq_pkg::S_DIV_WAIT;
      end
      sgcq_pkg::S_DIV_WAIT: begin
        if (!stat.div_busy) begin
          if (ax_r == sgcq_pkg::AX_Z) begin
            kind_nxt  = sgcq_pkg::SM_QUERY;
            ca_nxt    = '0;
            cb_nxt    = '0;
            state_nxt = sgcq_pkg::S_SCAN;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = sgcq_pkg::S_DIV_GO;
          end
        end
      end
      sgcq_pkg::S_SQ_GO: begin
        cmd.sq_start = 1'b1;
        state_nxt    = sgcq_pkg::S_SQ_WAIT;
      end
      sgcq_pkg::S_SQ_WAIT: begin
        if (!stat.sq_busy) begin
          state_nxt = sgcq_pkg::S_DONE;
        end
      end
      sgcq_pkg::S_DONE: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = sgcq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sgcq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/sgcq_dp.sv =====
// datapath: agent table, distance pipeline, cell divider, square root, output
module sgcq_dp #(
  parameter int MAX_AGENTS = 64,
  localparam int AW = $clog2(MAX_AGENTS)
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  sgcq_pkg::cmd_t                        cmd,
  input  logic [AW-1:0]                         rd_a,
  input  logic [AW-1:0]                         rd_b,
  input  logic [sgcq_pkg::IN_DATA_W-1:0]        in_tdata,
  input  logic [sgcq_pkg::IN_USER_W-1:0]        in_tuser,
  input  logic                                  cfg_we,
  input  logic [sgcq_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [sgcq_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                  out_tready,
  output logic                                  out_tvalid,
  output logic [sgcq_pkg::OUT_DATA_W-1:0]       out_tdata,
  output sgcq_pkg::dp_stat_t                    stat
);

  localparam int PW = sgcq_pkg::POS_W;
  localparam int DW = sgcq_pkg::DIFF_W;
  localparam int BW = sgcq_pkg::BND_W;

  // configuration registers
  logic [sgcq_pkg::CFG_W-1:0] cell_r, tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= sgcq_pkg::CELL_RST;
      tol_r  <= sgcq_pkg::TOL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        sgcq_pkg::CFG_CELL: cell_r <= cfg_wdata;
        sgcq_pkg::CFG_TOL:  tol_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // latched input word
  logic [sgcq_pkg::OP_W-1:0]  op_r;
  logic [sgcq_pkg::ID_W-1:0]  id_r;
  logic signed [PW-1:0]       px_r, py_r, pz_r;
  logic [sgcq_pkg::RAD_W-1:0] rad_r;
  logic [sgcq_pkg::LAY_W-1:0] lay_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r  <= in_tuser[sgcq_pkg::OP_W-1:0];
      id_r  <= in_tdata[15:0];
      px_r  <= in_tdata[39:16];
      py_r  <= in_tdata[63:40];
      pz_r  <= in_tdata[87:64];
      rad_r <= in_tdata[103:88];
      lay_r <= in_tdata[111:104];
    end
  end

  // table memory and occupancy bits
  sgcq_pkg::slot_t mem [MAX_AGENTS];
  sgcq_pkg::slot_t a_q, b_q, wr_word, s_word_r;
  logic [MAX_AGENTS-1:0] used_r;
  logic [AW-1:0]         s_idx_r, free_idx_r, wr_addr;
  logic                  wr_en;

  assign wr_en   = cmd.wr_add | cmd.wr_move;
  assign wr_addr = cmd.wr_add ? free_idx_r : s_idx_r;

  // new slot contents for add or move
  always_comb begin
    if (cmd.wr_add) begin
      wr_word.id     = id_r;
      wr_word.radius = rad_r;
      wr_word.layer  = lay_r;
    end else begin
      wr_word.id     = s_word_r.id;
      wr_word.radius = s_word_r.radius;
      wr_word.layer  = (sgcq_pkg::op_t'(op_r) == sgcq_pkg::OP_MOVE_SET) ? lay_r
                                                                       : s_word_r.layer;
    end
    wr_word.x = px_r;
    wr_word.y = py_r;
    wr_word.z = pz_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
    a_q <= mem[rd_a];
    b_q <= mem[rd_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (cmd.clr_all) begin
      used_r <= '0;
    end else if (cmd.wr_add) begin
      used_r[free_idx_r] <= 1'b1;
    end
  end

  // issue qualifier
  logic issue_q;

  always_comb begin
    case (cmd.mode)
      sgcq_pkg::SM_FIND:  issue_q = 1'b1;
      sgcq_pkg::SM_QUERY: issue_q = used_r[rd_b] && (rd_b != s_idx_r);
      sgcq_pkg::SM_PAIR:  issue_q = used_r[rd_a] && used_r[rd_b];
      default:            issue_q = 1'b0;
    endcase
  end

  // pipeline registers
  logic                       s1_v_r, s1_used_r, s2_v_r, s3_v_r;
  logic [AW-1:0]              s1_idx_r;
  logic [DW-1:0]              adx_r, ady_r, adz_r;
  logic [sgcq_pkg::RAD_W:0]   req_r;
  logic [2*DW-1:0]            sqx_r, sqy_r, sqz_r;
  logic [sgcq_pkg::RQ_W-1:0]  rq2_r;
  logic                       layer_ok, z_ok, in_win, elig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.rd_en & issue_q;
      s2_v_r <= s1_v_r & (cmd.mode != sgcq_pkg::SM_FIND) & elig;
      s3_v_r <= s2_v_r;
    end
  end

  // stage one: differences, layer, tolerance and cell window
  logic signed [PW-1:0] ax, ay, az;
  logic signed [DW-1:0] dx, dy, dz;
  logic [DW-1:0]        adx, ady, adz;
  logic signed [BW-1:0] bx_e, by_e, bz_e;
  logic signed [BW-1:0] lo_r [3];
  logic signed [BW-1:0] hi_r [3];

  always_comb begin
    ax   = (cmd.mode == sgcq_pkg::SM_PAIR) ? a_q.x : px_r;
    ay   = (cmd.mode == sgcq_pkg::SM_PAIR) ? a_q.y : py_r;
    az   = (cmd.mode == sgcq_pkg::SM_PAIR) ? a_q.z : pz_r;
    dx   = DW'(ax) - DW'(b_q.x);
    dy   = DW'(ay) - DW'(b_q.y);
    dz   = DW'(az) - DW'(b_q.z);
    adx  = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady  = dy[DW-1] ? DW'(-dy) : DW'(dy);
    adz  = dz[DW-1] ? DW'(-dz) : DW'(dz);
    bx_e = BW'(b_q.x);
    by_e = BW'(b_q.y);
    bz_e = BW'(b_q.z);
    layer_ok = (cmd.mode == sgcq_pkg::SM_PAIR) ? (a_q.layer == b_q.layer)
                                               : (s_word_r.layer == b_q.layer);
    z_ok   = adz <= DW'(tol_r);
    in_win = (bx_e >= lo_r[0]) && (bx_e < hi_r[0])
          && (by_e >= lo_r[1]) && (by_e < hi_r[1])
          && (bz_e >= lo_r[2]) && (bz_e < hi_r[2]);
    elig = layer_ok && z_ok && ((cmd.mode == sgcq_pkg::SM_PAIR) || in_win);
  end

  // stage two and three payload
  always_ff @(posedge clk) begin
    adx_r <= adx;
    ady_r <= ady;
    adz_r <= adz;
    req_r <= (sgcq_pkg::RAD_W + 1)'(rad_r) + (sgcq_pkg::RAD_W + 1)'(b_q.radius);
    sqx_r <= adx_r * adx_r;
    sqy_r <= ady_r * ady_r;
    sqz_r <= adz_r * adz_r;
    rq2_r <= req_r * req_r;
  end

  // stage four: squared distance
  logic [sgcq_pkg::D2_W-1:0] d2, best_r;

  assign d2 = sgcq_pkg::D2_W'(sqx_r) + sgcq_pkg::D2_W'(sqy_r) + sgcq_pkg::D2_W'(sqz_r);

  // scan result flags
  logic found_r, free_found_r, hit_r, pair_found_r;
  logic find_v, pair_upd;

  assign find_v   = s1_v_r && (cmd.mode == sgcq_pkg::SM_FIND);
  assign pair_upd = s3_v_r && (cmd.mode == sgcq_pkg::SM_PAIR)
                 && (!pair_found_r || d2 < best_r);

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.latch) begin
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      hit_r        <= 1'b0;
      pair_found_r <= 1'b0;
    end else begin
      if (find_v && s1_used_r && b_q.id == id_r) begin
        found_r <= 1'b1;
      end
      if (find_v && !s1_used_r) begin
        free_found_r <= 1'b1;
      end
      if (s3_v_r && cmd.mode == sgcq_pkg::SM_QUERY
          && d2 < sgcq_pkg::D2_W'(rq2_r)) begin
        hit_r <= 1'b1;
      end
      if (pair_upd) begin
        pair_found_r <= 1'b1;
      end
    end
  end

  // captured slot index, slot word, free slot and best distance
  always_ff @(posedge clk) begin
    s1_used_r <= used_r[rd_b];
    s1_idx_r  <= rd_b;
    if (find_v && s1_used_r && b_q.id == id_r) begin
      s_idx_r  <= s1_idx_r;
      s_word_r <= b_q;
    end
    if (find_v && !s1_used_r && !free_found_r) begin
      free_idx_r <= s1_idx_r;
    end
    if (pair_upd) begin
      best_r <= d2;
    end
  end

  // cell divider: floor(p / size), then window bounds (q-1)*size .. (q+2)*size
  logic                              dv_busy_r;
  logic [sgcq_pkg::DIV_CNT_W-1:0]    dv_cnt_r;
  logic [1:0]                        dv_axis_r;
  logic                              dv_neg_r;
  logic [sgcq_pkg::CFG_W-1:0]        dv_rem_r, dv_s;
  logic [PW-1:0]                     dv_quo_r, dv_mag;
  logic signed [PW-1:0]              dv_a;
  logic signed [sgcq_pkg::DQ_W-1:0]  dv_qf_r;
  logic [sgcq_pkg::CFG_W:0]          dv_tmp;
  logic signed [sgcq_pkg::DQ_W+sgcq_pkg::CFG_W:0] dv_prod;
  logic signed [BW-1:0]              dv_lo, dv_hi;

  always_comb begin
    case (cmd.axis)
      sgcq_pkg::AX_X: dv_a = px_r;
      sgcq_pkg::AX_Y: dv_a = py_r;
      default:        dv_a = pz_r;
    endcase
    dv_mag  = dv_a[PW-1] ? PW'(-dv_a) : PW'(dv_a);
    dv_s    = (dv_axis_r == sgcq_pkg::AX_Z) ? tol_r : cell_r;
    dv_tmp  = {dv_rem_r, dv_quo_r[PW-1]};
    dv_prod = dv_qf_r * $signed({1'b0, dv_s});
    dv_lo   = BW'(dv_prod) - BW'(dv_s);
    dv_hi   = BW'(dv_prod) + BW'(dv_s) + BW'(dv_s);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy_r <= 1'b1;
    end else if (dv_busy_r && dv_cnt_r == sgcq_pkg::DIV_CNT_W'(sgcq_pkg::DIV_STEPS + 1)) begin
      dv_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_cnt_r  <= '0;
      dv_axis_r <= cmd.axis;
      dv_neg_r  <= dv_a[PW-1];
      dv_quo_r  <= dv_mag;
      dv_rem_r  <= '0;
    end else if (dv_busy_r) begin
      dv_cnt_r <= dv_cnt_r + sgcq_pkg::DIV_CNT_W'(1);
      if (dv_cnt_r < sgcq_pkg::DIV_CNT_W'(sgcq_pkg::DIV_STEPS)) begin
        // one restoring step per cycle
        if (dv_tmp >= {1'b0, dv_s}) begin
          dv_rem_r <= sgcq_pkg::CFG_W'(dv_tmp - {1'b0, dv_s});
          dv_quo_r <= {dv_quo_r[PW-2:0], 1'b1};
        end else begin
          dv_rem_r <= sgcq_pkg::CFG_W'(dv_tmp);
          dv_quo_r <= {dv_quo_r[PW-2:0], 1'b0};
        end
      end else if (dv_cnt_r == sgcq_pkg::DIV_CNT_W'(sgcq_pkg::DIV_STEPS)) begin
        // round toward minus infinity for negative positions
        dv_qf_r <= dv_neg_r
          ? -(sgcq_pkg::DQ_W'(dv_quo_r) + sgcq_pkg::DQ_W'(dv_rem_r != '0))
          : sgcq_pkg::DQ_W'(dv_quo_r);
      end else begin
        case (dv_axis_r)
          sgcq_pkg::AX_X: begin
            lo_r[0] <= dv_lo;
            hi_r[0] <= dv_hi;
          end
          sgcq_pkg::AX_Y: begin
            lo_r[1] <= dv_lo;
            hi_r[1] <= dv_hi;
          end
          default: begin
            lo_r[2] <= dv_lo;
            hi_r[2] <= dv_hi;
          end
        endcase
      end
    end
  end

  // floor square root, one result bit per cycle
  logic                              sq_busy_r;
  logic [sgcq_pkg::SQ_CNT_W-1:0]     sq_cnt_r;
  logic [sgcq_pkg::D2_W-1:0]         sq_v_r;
  logic [sgcq_pkg::SQ_REM_W-1:0]     sq_rem_r;
  logic [sgcq_pkg::SEP_W-1:0]        sq_root_r;
  logic [sgcq_pkg::SQ_REM_W+1:0]     sq_t, sq_trial;

  assign sq_t     = {sq_rem_r, sq_v_r[sgcq_pkg::D2_W-1 -: 2]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.sq_start) begin
      sq_busy_r <= 1'b1;
    end else if (sq_busy_r && sq_cnt_r == sgcq_pkg::SQ_CNT_W'(sgcq_pkg::SQ_STEPS - 1)) begin
      sq_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_start) begin
      sq_cnt_r  <= '0;
      sq_v_r    <= best_r;
      sq_rem_r  <= '0;
      sq_root_r <= '0;
    end else if (sq_busy_r) begin
      sq_cnt_r <= sq_cnt_r + sgcq_pkg::SQ_CNT_W'(1);
      sq_v_r   <= {sq_v_r[sgcq_pkg::D2_W-3:0], 2'b00};
      if (sq_t >= sq_trial) begin
        sq_rem_r  <= sgcq_pkg::SQ_REM_W'(sq_t - sq_trial);
        sq_root_r <= {sq_root_r[sgcq_pkg::SEP_W-2:0], 1'b1};
      end else begin
        sq_rem_r  <= sgcq_pkg::SQ_REM_W'(sq_t);
        sq_root_r <= {sq_root_r[sgcq_pkg::SEP_W-2:0], 1'b0};
      end
    end
  end

  // result word
  logic                       cfg_zero, id_zero;
  logic                       res_ans, res_np;
  sgcq_pkg::sts_t             res_sts;
  logic [sgcq_pkg::SEP_W-1:0] res_sep;

  assign cfg_zero = (cell_r == '0) || (tol_r == '0);
  assign id_zero  = (id_r == '0);

  always_comb begin
    res_ans = 1'b0;
    res_sts = sgcq_pkg::STS_OK;
    res_sep = '0;
    res_np  = 1'b0;
    case (sgcq_pkg::op_t'(op_r))
      sgcq_pkg::OP_CLEAR: begin
        res_ans = 1'b1;
      end
      sgcq_pkg::OP_ADD: begin
        if (id_zero || found_r) begin
          res_sts = sgcq_pkg::STS_BADID;
        end else if (!free_found_r) begin
          res_sts = sgcq_pkg::STS_FULL;
        end else begin
          res_ans = 1'b1;
        end
      end
      sgcq_pkg::OP_MOVE_KEEP, sgcq_pkg::OP_MOVE_SET: begin
        if (id_zero) begin
          res_sts = sgcq_pkg::STS_BADID;
        end else if (!found_r) begin
          res_sts = sgcq_pkg::STS_UNKNOWN;
        end else begin
          res_ans = 1'b1;
        end
      end
      sgcq_pkg::OP_QUERY: begin
        if (id_zero) begin
          res_sts = sgcq_pkg::STS_BADID;
        end else if (!found_r) begin
          res_sts = sgcq_pkg::STS_UNKNOWN;
        end else if (cfg_zero || hit_r) begin
          res_sts = sgcq_pkg::STS_UNSAFE;
        end else begin
          res_ans = 1'b1;
        end
      end
      sgcq_pkg::OP_MINSEP: begin
        if (pair_found_r) begin
          res_ans = 1'b1;
          res_sep = sq_root_r;
        end else begin
          res_np = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // output register
  logic                              out_valid_r;
  logic [sgcq_pkg::OUT_DATA_W-1:0]   out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {2'b00, res_np, res_sep, res_sts, res_ans};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // status back to the controller
  always_comb begin
    stat.op         = op_r;
    stat.id_zero    = id_zero;
    stat.found      = found_r;
    stat.free_found = free_found_r;
    stat.pair_found = pair_found_r;
    stat.cfg_zero   = cfg_zero;
    stat.div_busy   = dv_busy_r;
    stat.sq_busy    = sq_busy_r;
    stat.out_busy   = out_valid_r & ~out_tready;
  end

endmodule

// ===== rtl/spatial_grid_collision_query.sv =====
// top level of the spatial grid collision query block
//
//  channel  dir  handshake               payload
//  in_      in   in_tvalid / in_tready   in_tdata 112b, in_tuser 8b
//  out_     out  out_tvalid / out_tready out_tdata 32b
//  cfg_     in   cfg_we                  cfg_addr 2b, cfg_wdata 20b
//
// one word at a time; clear and id-zero words skip the table scan, add and
// move scan it (one table slot read per cycle), a safety query adds three
// cell divisions and a second slot scan, and minimum separation walks all
// MAX_AGENTS*(MAX_AGENTS-1)/2 pairs when no register is zero (one pair per
// cycle on the two memory read ports), drains and roots any best distance.
// synchronous active-low reset empties the table and loads default registers.
// a finished result waits in the output register; a new word is taken once
// the previous result has been loaded there.
module spatial_grid_collision_query #(
  parameter int MAX_AGENTS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // id[15:0], pos_x[39:16], pos_y[63:40], pos_z[87:64], radius[103:88],
  // layer[111:104]
  input  logic [sgcq_pkg::IN_DATA_W-1:0]      in_tdata,
  // operation[2:0], zero above
  input  logic [sgcq_pkg::IN_USER_W-1:0]      in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // answer[0], status[3:1], separation[28:4], no_pair[29], zero above
  output logic [sgcq_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [sgcq_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sgcq_pkg::CFG_W-1:0]          cfg_wdata
);

  localparam int AW = $clog2(MAX_AGENTS);

  sgcq_pkg::cmd_t     cmd;
  sgcq_pkg::dp_stat_t stat;
  logic [AW-1:0]      rd_a, rd_b;

  // controller
  sgcq_ctrl #(
    .MAX_AGENTS (MAX_AGENTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd),
    .rd_a      (rd_a),
    .rd_b      (rd_b)
  );

  // datapath
  sgcq_dp #(
    .MAX_AGENTS (MAX_AGENTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .stat       (stat)
  );

endmodule

// ===== test/sgcq_checker.sv =====
// scoreboard for the spatial grid collision query block: predicts and checks every result word
`timescale 1ns / 100ps

module sgcq_checker #(
  parameter int MAX_AGENTS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [sgcq_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [sgcq_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [sgcq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic                            cfg_we,
  input  logic [sgcq_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sgcq_pkg::CFG_W-1:0]      cfg_wdata,
  output int                              fail_count,
  output int                              pending,
  output int                              checked
);

  typedef struct {
    logic                       answer;
    logic [sgcq_pkg::STS_W-1:0] status;
    logic [sgcq_pkg::SEP_W-1:0] separation;
    logic                       no_pair;
  } result_t;

  // shadow copy of the agent table and registers
  logic [sgcq_pkg::CFG_W-1:0] cell_sz, tol;
  logic                       used [MAX_AGENTS];
  sgcq_pkg::slot_t            agent [MAX_AGENTS];
  result_t                    expected_q [$];

  assign pending = expected_q.size();

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic bit same_cell(longint a, longint b, longint sz);
    longint d;
    d = fdiv(a, sz) - fdiv(b, sz);
    return d >= -1 && d <= 1;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  // floor root, one bit at a time from the top
  function automatic longint root_floor(longint v);
    longint r, t;
    r = 0;
    for (int b = sgcq_pkg::SEP_W; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic longint dist_sq(longint ax, longint ay, longint az,
                                     sgcq_pkg::slot_t o);
    longint dx, dy, dz;
    dx = ax - o.x;
    dy = ay - o.y;
    dz = az - o.z;
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic int slot_of(logic [sgcq_pkg::ID_W-1:0] id);
    for (int i = 0; i < MAX_AGENTS; i++)
      if (used[i] && agent[i].id == id) return i;
    return -1;
  endfunction

  // work out the result of one word and update the shadow table
  function automatic result_t predict_word(logic [sgcq_pkg::OP_W-1:0] op,
                                           sgcq_pkg::slot_t w);
    result_t r;
    int      s, fr;
    bit      hit, found;
    longint  best, d, req;
    r = '{answer: 1'b0, status: sgcq_pkg::STS_OK, separation: '0, no_pair: 1'b0};
    if (op == sgcq_pkg::OP_CLEAR) begin
      foreach (used[i]) used[i] = 1'b0;
      r.answer = 1'b1;
    end else if (op == sgcq_pkg::OP_ADD) begin
      fr = -1;
      for (int i = MAX_AGENTS - 1; i >= 0; i--) if (!used[i]) fr = i;
      if (w.id == 0 || slot_of(w.id) >= 0) begin
        foreach (used[i]) used[i] = 1'b0;
        r.status = sgcq_pkg::STS_BADID;
      end else if (fr < 0) begin
        foreach (used[i]) used[i] = 1'b0;
        r.status = sgcq_pkg::STS_FULL;
      end else begin
        used[fr]  = 1'b1;
        agent[fr] = w;
        r.answer  = 1'b1;
      end
    end else if (op == sgcq_pkg::OP_MOVE_KEEP || op == sgcq_pkg::OP_MOVE_SET
                 || op == sgcq_pkg::OP_QUERY) begin
      s = (w.id == 0) ? -1 : slot_of(w.id);
      if (w.id == 0) r.status = sgcq_pkg::STS_BADID;
      else if (s < 0) r.status = sgcq_pkg::STS_UNKNOWN;
      else if (op != sgcq_pkg::OP_QUERY) begin
        agent[s].x = w.x;
        agent[s].y = w.y;
        agent[s].z = w.z;
        if (op == sgcq_pkg::OP_MOVE_SET) agent[s].layer = w.layer;
        r.answer = 1'b1;
      end else if (cell_sz == 0 || tol == 0) begin
        r.status = sgcq_pkg::STS_UNSAFE;
      end else begin
        hit = 0;
        for (int i = 0; i < MAX_AGENTS && !hit; i++) begin
          if (!used[i] || i == s) continue;
          if (!same_cell(w.x, agent[i].x, cell_sz) || !same_cell(w.y, agent[i].y, cell_sz)
              || !same_cell(w.z, agent[i].z, tol)) continue;
          if (agent[i].layer != agent[s].layer
              || labs(longint'(w.z) - agent[i].z) > longint'(tol)) continue;
          req = longint'(w.radius) + agent[i].radius;
          if (dist_sq(w.x, w.y, w.z, agent[i]) < req * req) hit = 1;
        end
        if (hit) r.status = sgcq_pkg::STS_UNSAFE;
        else r.answer = 1'b1;
      end
    end else if (op == sgcq_pkg::OP_MINSEP) begin
      found = 0;
      best  = 0;
      if (cell_sz != 0 && tol != 0) begin
        for (int i = 0; i < MAX_AGENTS; i++) begin
          if (!used[i]) continue;
          for (int j = i + 1; j < MAX_AGENTS; j++) begin
            if (!used[j] || agent[i].layer != agent[j].layer
                || labs(longint'(agent[i].z) - agent[j].z) > longint'(tol)) continue;
            d = dist_sq(agent[i].x, agent[i].y, agent[i].z, agent[j]);
            if (!found || d < best) begin
              best  = d;
              found = 1;
            end
          end
        end
      end
      if (found) begin
        r.answer     = 1'b1;
        r.separation = sgcq_pkg::SEP_W'(root_floor(best));
      end else begin
        r.no_pair = 1'b1;
      end
    end
    return r;
  endfunction

  // watch the three ports; results are retired before the new word is predicted
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst_n) begin
      cell_sz = sgcq_pkg::CELL_RST;
      tol     = sgcq_pkg::TOL_RST;
      foreach (used[i]) used[i] = 1'b0;
      expected_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $error("result word with no expectation: %h", out_tdata);
          fail_count++;
        end else begin
          exp_r = expected_q.pop_front();
          if (out_tdata[0] !== exp_r.answer) begin
            $error("answer: expected %0d, got %0d", exp_r.answer, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[3:1] !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tdata[3:1]);
            fail_count++;
          end
          if (out_tdata[28:4] !== exp_r.separation) begin
            $error("separation: expected %0d, got %0d", exp_r.separation, out_tdata[28:4]);
            fail_count++;
          end
          if (out_tdata[29] !== exp_r.no_pair) begin
            $error("no_pair: expected %0d, got %0d", exp_r.no_pair, out_tdata[29]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(predict_word(in_tuser[sgcq_pkg::OP_W-1:0],
                                          sgcq_pkg::slot_t'(in_tdata)));
      if (cfg_we) begin
        if (cfg_addr == sgcq_pkg::CFG_CELL) cell_sz = cfg_wdata;
        else if (cfg_addr == sgcq_pkg::CFG_TOL) tol = cfg_wdata;
      end
    end
  end

endmodule

// ===== test/tb_spatial_grid_collision_query.sv =====
// testbench top for the spatial grid collision query block: stimulus, backpressure and verdict
`timescale 1ns / 100ps

module tb_spatial_grid_collision_query;

  localparam int  AGENTS  = 64;
  localparam longint LIMIT = 20_000_000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [sgcq_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic [sgcq_pkg::IN_USER_W-1:0]  in_tuser = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [sgcq_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic                            cfg_we = 1'b0;
  logic [sgcq_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [sgcq_pkg::CFG_W-1:0]      cfg_wdata = '0;
  int                              fail_count, pending, checked;
  int                              words_sent = 0;
  int                              burst_left = 0;
  int                              phases = 0;
  longint                          cycles = 0;
  bit                              hold_go = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  spatial_grid_collision_query #(.MAX_AGENTS(AGENTS)) DUT (.*);

  sgcq_checker #(.MAX_AGENTS(AGENTS)) u_checker (.*);

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("[spatial_grid_collision_query] ERROR");
      $finish;
    end
  end

  // receiver: a long hold once when asked, otherwise stretches of full rate and random stalls
  initial begin
    int hold_cnt;
    bit hold_done;
    hold_cnt  = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_cnt  = 600;
        hold_done = 1;
      end
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else if ((cycles % 3000) < 800) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // one input word, sent in bursts with random gaps
  task automatic send_word(logic [sgcq_pkg::OP_W-1:0] op, logic [sgcq_pkg::ID_W-1:0] id,
                           logic [sgcq_pkg::POS_W-1:0] x, logic [sgcq_pkg::POS_W-1:0] y,
                           logic [sgcq_pkg::POS_W-1:0] z, logic [sgcq_pkg::RAD_W-1:0] rad,
                           logic [sgcq_pkg::LAY_W-1:0] lay);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tdata  <= {lay, rad, z, y, x, id};
    in_tuser  <= sgcq_pkg::IN_USER_W'(op);
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [sgcq_pkg::CFG_ADDR_W-1:0] idx,
                           logic [sgcq_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // clustered positions so neighbors and hits are common, sometimes the full range
  function automatic logic [sgcq_pkg::POS_W-1:0] rand_pos(int span);
    if ($urandom_range(0, 9) == 0) return sgcq_pkg::POS_W'($urandom);
    return sgcq_pkg::POS_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic [sgcq_pkg::ID_W-1:0] rand_id();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return sgcq_pkg::ID_W'($urandom);
    return sgcq_pkg::ID_W'($urandom_range(1, 48));
  endfunction

  task automatic random_words(int n);
    int k, span;
    logic [sgcq_pkg::OP_W-1:0] op;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) op = sgcq_pkg::OP_ADD;
      else if (k < 42) op = sgcq_pkg::OP_MOVE_KEEP;
      else if (k < 52) op = sgcq_pkg::OP_MOVE_SET;
      else if (k < 88) op = sgcq_pkg::OP_QUERY;
      else if (k < 94) op = sgcq_pkg::OP_MINSEP;
      else if (k < 97) op = sgcq_pkg::OP_CLEAR;
      else op = sgcq_pkg::OP_W'($urandom_range(6, 7));
      span = ($urandom_range(0, 1) == 0) ? 1500 : 6000;
      send_word(op, rand_id(), rand_pos(span), rand_pos(span), rand_pos(span / 2),
                ($urandom_range(0, 3) == 0) ? sgcq_pkg::RAD_W'($urandom)
                                            : sgcq_pkg::RAD_W'($urandom_range(0, 1200)),
                ($urandom_range(0, 7) == 0) ? sgcq_pkg::LAY_W'($urandom)
                                            : sgcq_pkg::LAY_W'($urandom_range(0, 2)));
    end
  endtask

  // fill the table to capacity, then one more add overflows it
  task automatic fill_table;
    send_word(sgcq_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
    for (int i = 0; i <= AGENTS; i++)
      send_word(sgcq_pkg::OP_ADD, sgcq_pkg::ID_W'(200 + i), rand_pos(3000), rand_pos(3000),
                rand_pos(500), sgcq_pkg::RAD_W'($urandom_range(0, 400)),
                sgcq_pkg::LAY_W'($urandom_range(0, 1)));
  endtask

  initial begin
    logic [sgcq_pkg::CFG_W-1:0] cells [7];
    logic [sgcq_pkg::CFG_W-1:0] tols  [7];
    cells = '{20'd64, 20'd1, 20'd1048575, 20'd0, 20'd800, 20'd3000, 20'd800};
    tols  = '{20'd32, 20'd1, 20'd1048575, 20'd400, 20'd0, 20'd1500, 20'd400};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings
    send_word(sgcq_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_ADD, '0, '0, '0, '0, 16'd10, '0);
    send_word(sgcq_pkg::OP_ADD, 16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 8'hFF);
    send_word(sgcq_pkg::OP_ADD, 16'd1, 24'h800000, 24'h800000, 24'h800000, 16'hFFFF, 8'hFF);
    send_word(sgcq_pkg::OP_MINSEP, '0, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_ADD, 16'd1, '0, '0, '0, 16'd5, '0);
    send_word(sgcq_pkg::OP_ADD, 16'd1, 24'd0, 24'd0, 24'd0, 16'd100, 8'd0);
    send_word(sgcq_pkg::OP_ADD, 16'd2, 24'd150, 24'd0, 24'd10, 16'd100, 8'd0);
    send_word(sgcq_pkg::OP_ADD, 16'd3, -24'sd300, 24'd90, 24'd0, 16'd50, 8'd1);
    send_word(sgcq_pkg::OP_QUERY, 16'd1, 24'd0, 24'd0, 24'd0, 16'd100, '0);
    send_word(sgcq_pkg::OP_QUERY, 16'd1, -24'sd900, 24'd0, 24'd0, 16'd10, '0);
    send_word(sgcq_pkg::OP_QUERY, '0, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_QUERY, 16'd77, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_MOVE_KEEP, 16'd77, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_MOVE_SET, '0, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_MINSEP, '0, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_MOVE_KEEP, 16'd3, 24'd10, 24'd20, 24'd30, 16'd9, 8'd7);
    send_word(sgcq_pkg::OP_MOVE_SET, 16'd2, 24'd10, 24'd20, 24'd900, 16'd9, 8'd1);
    send_word(sgcq_pkg::OP_MINSEP, '0, '0, '0, '0, '0, '0);
    send_word(3'd6, 16'd1, '0, '0, '0, '0, '0);
    send_word(3'd7, 16'd2, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_CLEAR, '0, '0, '0, '0, '0, '0);
    send_word(sgcq_pkg::OP_MINSEP, '0, '0, '0, '0, '0, '0);

    // long output hold while words keep coming
    hold_go = 1;
    random_words(230);
    drain();

    // register settings, extremes and zero among them
    for (int p = 0; p < 7; p++) begin
      write_reg(sgcq_pkg::CFG_CELL, cells[p]);
      write_reg(sgcq_pkg::CFG_TOL, tols[p]);
      if (p == 1) write_reg(2'd2, 20'hFFFFF);
      if (p == 4) write_reg(2'd3, 20'h12345);
      phases++;
      if (p == 0 || p == 6) fill_table();
      random_words(p == 0 || p == 6 ? 120 : 190);
      drain();
    end

    $display("covered %0d words and %0d results over %0d register settings",
             words_sent, checked, phases + 1);
    if (fail_count == 0) begin
      $display("[spatial_grid_collision_query] OK");
    end else begin
      $display("[spatial_grid_collision_query] ERROR");
    end
    $finish;
  end

endmodule
